/* hdl/socks5_pkg.sv */
// ----------------------------------------------------------------------------
// SOCKS5 request parser package
// Shared item types, parser phases, status codes and protocol constants.
// ----------------------------------------------------------------------------
package socks5_pkg;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_COMMAND  = 4'd1,
    PH_RESERVED = 4'd2,
    PH_ATYPE    = 4'd3,
    PH_NAMELEN  = 4'd4,
    PH_ADDRESS  = 4'd5,
    PH_PORT     = 4'd6,
    PH_DONE     = 4'd7,
    PH_BADVER   = 4'd8,
    PH_BADCMD   = 4'd9,
    PH_BADATYP  = 4'd10,
    PH_NORSV    = 4'd11
  } phase_e;

  // Reported status codes.
  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_BADVER   = 3'd2,
    ST_BADCMD   = 3'd3,
    ST_BADATYP  = 3'd4,
    ST_NORSV    = 3'd5
  } status_e;

  // Protocol constants.
  localparam logic [7:0] VersionReset = 8'd5;
  localparam logic [7:0] ReservedByte = 8'h00;
  localparam logic [7:0] CmdConnect   = 8'd1;
  localparam logic [7:0] CmdUdpAssoc  = 8'd3;
  localparam logic [7:0] AtypIpv4     = 8'd1;
  localparam logic [7:0] AtypDomain   = 8'd3;
  localparam logic [7:0] AtypIpv6     = 8'd4;
  localparam logic [7:0] Ipv4Len      = 8'd4;
  localparam logic [7:0] Ipv6Len      = 8'd16;
  localparam logic [7:0] PortBytes    = 8'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  command;
    logic [7:0]  address_kind;
    logic        addr_valid;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [7:0]  name_length;
    logic [15:0] dest_port;
  } out_item_t;

  // Terminal phases report their own status; all others are busy.
  function automatic status_e status_of(input phase_e ph);
    status_e st;
    unique case (ph)
      PH_DONE:    st = ST_DONE;
      PH_BADVER:  st = ST_BADVER;
      PH_BADCMD:  st = ST_BADCMD;
      PH_BADATYP: st = ST_BADATYP;
      PH_NORSV:   st = ST_NORSV;
      default:    st = ST_BUSY;
    endcase
    return st;
  endfunction

endpackage

/* hdl/socks5_request_parser_top.sv */
// ----------------------------------------------------------------------------
// SOCKS5 request parser
// Byte-at-a-time parser for the SOCKS5 request header with streamed address.
// ----------------------------------------------------------------------------
// The parser takes one request byte per input item and returns exactly one
// result item per byte, describing the parser after that byte. It accepts a
// byte in every clock cycle unless the result stalls: the parser state and
// the result register are updated in the same cycle, and the result register
// is refilled on the very edge at which its previous item is taken, so the
// sustained rate is one item per cycle while out_ready_i is high; results are registered.
// in_ready_o falls only while a finished result waits with out_ready_i low.
// The first byte must match the expected_version register (reset value 5),
// then come the command (connect, bind or UDP associate), a zero reserved
// byte and the address type. IPv4 carries 4 address bytes, IPv6 carries 16,
// and a domain carries a length byte followed by that many bytes; a length of
// zero goes straight to the port. Address bytes are not stored: each one is
// reported with addr_valid set and its position in addr_index. The two port
// bytes arrive high byte first. Done and every error are terminal: later
// bytes repeat the same status until an item arrives with restart set, which
// makes that byte the version byte of a new request. The configuration port
// is always ready and should be written only while the parser is idle.
// ----------------------------------------------------------------------------
module socks5_request_parser_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request byte channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  socks5_pkg::in_item_t  in_data_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output socks5_pkg::out_item_t out_data_o,
  // Configuration: expected version byte.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i
);
  import socks5_pkg::*;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  byte_pos_q, byte_pos_d;
  logic [1:0]  command_q, command_d;
  logic [7:0]  atyp_q, atyp_d;
  logic [7:0]  length_q, length_d;
  logic [15:0] port_q, port_d;
  logic [7:0]  exp_ver_q;

  // Result register.
  logic        out_valid_q;
  out_item_t   out_q, out_d;

  // State as seen by this byte, after an optional restart.
  phase_e      ph_eff;
  logic [7:0]  left_eff, pos_eff, atyp_eff, len_eff;
  logic [1:0]  cmd_eff;
  logic [15:0] port_eff;
  logic [7:0]  left_dec;
  logic [7:0]  b;
  logic        in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    b = in_data_i.data_byte;
    if (in_data_i.restart) begin
      ph_eff   = PH_VERSION;
      left_eff = '0;
      pos_eff  = '0;
      cmd_eff  = '0;
      atyp_eff = '0;
      len_eff  = '0;
      port_eff = '0;
    end else begin
      ph_eff   = phase_q;
      left_eff = bytes_left_q;
      pos_eff  = byte_pos_q;
      cmd_eff  = command_q;
      atyp_eff = atyp_q;
      len_eff  = length_q;
      port_eff = port_q;
    end
    left_dec = left_eff - 8'd1;

    phase_d      = ph_eff;
    bytes_left_d = left_eff;
    byte_pos_d   = pos_eff;
    command_d    = cmd_eff;
    atyp_d       = atyp_eff;
    length_d     = len_eff;
    port_d       = port_eff;

    out_d            = '0;
    out_d.addr_valid = 1'b0;

    unique case (ph_eff)
      PH_VERSION: begin
        phase_d = (b == exp_ver_q) ? PH_COMMAND : PH_BADVER;
      end
      PH_COMMAND: begin
        if (b >= CmdConnect && b <= CmdUdpAssoc) begin
          command_d = b[1:0];
          phase_d   = PH_RESERVED;
        end else begin
          phase_d = PH_BADCMD;
        end
      end
      PH_RESERVED: begin
        phase_d = (b == ReservedByte) ? PH_ATYPE : PH_NORSV;
      end
      PH_ATYPE: begin
        atyp_d     = b;
        byte_pos_d = '0;
        priority if (b == AtypIpv4) begin
          length_d     = Ipv4Len;
          bytes_left_d = Ipv4Len;
          phase_d      = PH_ADDRESS;
        end else if (b == AtypIpv6) begin
          length_d     = Ipv6Len;
          bytes_left_d = Ipv6Len;
          phase_d      = PH_ADDRESS;
        end else if (b == AtypDomain) begin
          phase_d = PH_NAMELEN;
        end else begin
          phase_d = PH_BADATYP;
        end
      end
      PH_NAMELEN: begin
        length_d = b;
        if (b == 8'd0) begin
          bytes_left_d = PortBytes;
          phase_d      = PH_PORT;
        end else begin
          bytes_left_d = b;
          phase_d      = PH_ADDRESS;
        end
      end
      PH_ADDRESS: begin
        out_d.addr_valid = 1'b1;
        out_d.addr_byte  = b;
        out_d.addr_index = pos_eff;
        byte_pos_d       = pos_eff + 8'd1;
        if (left_dec == 8'd0) begin
          bytes_left_d = PortBytes;
          phase_d      = PH_PORT;
        end else begin
          bytes_left_d = left_dec;
        end
      end
      PH_PORT: begin
        port_d       = {port_eff[7:0], b};
        bytes_left_d = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = PH_DONE;
        end
      end
      default: begin
        // Terminal phases ignore the byte.
      end
    endcase

    out_d.status       = status_of(phase_d);
    out_d.command      = command_d;
    out_d.address_kind = atyp_d;
    out_d.name_length  = length_d;
    out_d.dest_port    = port_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_VERSION;
      bytes_left_q <= '0;
      byte_pos_q   <= '0;
      command_q    <= '0;
      atyp_q       <= '0;
      length_q     <= '0;
      port_q       <= '0;
      exp_ver_q    <= VersionReset;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        exp_ver_q <= cfg_data_i;
      end
      if (in_fire) begin
        phase_q      <= phase_d;
        bytes_left_q <= bytes_left_d;
        byte_pos_q   <= byte_pos_d;
        command_q    <= command_d;
        atyp_q       <= atyp_d;
        length_q     <= length_d;
        port_q       <= port_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  // Address bytes are only reported while the request is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.addr_valid |-> out_q.status == ST_BUSY && out_q.name_length != 8'd0)
    else $error("address byte reported outside the address phase");

  // Done is terminal until a byte with restart is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE && !(in_fire && in_data_i.restart) |=> phase_q == PH_DONE)
    else $error("done phase left without restart");

  // A configuration write lands in the version register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> exp_ver_q == $past(cfg_data_i))
    else $error("expected version not updated");

  // An address position never reaches the declared length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ADDRESS |-> byte_pos_q < length_q)
    else $error("address position beyond length");
`endif

endmodule
